// ===== hw/rtl/tsws_pkg.sv =====
// tsws_pkg: widths, register indexes, reset values and handshake structs
// shared by the triangle sweep core and its serial arithmetic units
// no dependencies
`default_nettype none

package tsws_pkg;

    localparam int ELAPSED_W = 40;
    localparam int PER_W     = 26;
    localparam int ANGLE_W   = 16;
    localparam int THR_W     = 42;
    localparam int DIVD_W    = THR_W;                 // shared divider dividend width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = PER_W;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
    localparam int MUL_CNT_W = $clog2(PER_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 2'd2;

    localparam logic [PER_W-1:0]   PERIOD_RST    = 26'd5000000;
    localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST = 16'hD666;   // -10650
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 16'd4915;
    localparam logic [THR_W-1:0]   THR_MAX       = {THR_W{1'b1}};

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [PER_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [PER_W-1:0]  remainder;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [ANGLE_W-1:0] mcand;
        logic [PER_W-1:0]   mplier;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] product;
    } mul_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsws_if.sv =====
// tsws_in_if / tsws_out_if: valid/ready channels for event and result beats
// depends on tsws_pkg
`default_nettype none

interface tsws_in_if;
    logic                          valid;
    logic                          ready;
    logic [tsws_pkg::ELAPSED_W-1:0] elapsed_us;

    modport source (output valid, output elapsed_us, input ready);
    modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface tsws_out_if;
    logic                        valid;
    logic                        ready;
    logic [tsws_pkg::ANGLE_W-1:0] angle_cmd;
    logic                        shutter_pulse;

    modport source (output valid, output angle_cmd, output shutter_pulse, input ready);
    modport sink   (input valid, input angle_cmd, input shutter_pulse, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tsws_div.sv =====
// tsws_div: restoring divider, one quotient bit per cycle
// depends on tsws_pkg
`default_nettype none

module tsws_div (
    input  wire               clk,
    input  wire               rst_n,
    input  tsws_pkg::div_req_t req,
    output tsws_pkg::div_rsp_t rsp
);
    import tsws_pkg::*;

    logic [DIVD_W-1:0]    num_reg, num_next;     // dividend in, quotient out
    logic [PER_W-1:0]     rem_reg, rem_next;
    logic [PER_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [PER_W:0]       trial;
    logic                 ge;

    assign trial = {rem_reg, num_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            num_next = req.dividend;
            rem_next = '0;
            den_next = req.divisor;
            cnt_next = DIV_CNT_W'(DIVD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? PER_W'(trial - {1'b0, den_reg}) : trial[PER_W-1:0];
            num_next = {num_reg[DIVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = num_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tsws_mul.sv =====
// tsws_mul: shift-add multiplier, one multiplier bit per cycle, lsb first
// depends on tsws_pkg
`default_nettype none

module tsws_mul (
    input  wire               clk,
    input  wire               rst_n,
    input  tsws_pkg::mul_req_t req,
    output tsws_pkg::mul_rsp_t rsp
);
    import tsws_pkg::*;

    logic [ANGLE_W-1:0]   acc_reg, acc_next;   // upper product half
    logic [PER_W-1:0]     sh_reg, sh_next;     // multiplier out, lower product in
    logic [ANGLE_W-1:0]   mc_reg, mc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [ANGLE_W:0]     sum;

    assign sum = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, mc_reg} : '0);

    always_comb
    begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        mc_next   = mc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next = '0;
            sh_next  = req.mplier;
            mc_next  = req.mcand;
            cnt_next = MUL_CNT_W'(PER_W);
        end
        else if (cnt_reg != '0)
        begin
            acc_next = sum[ANGLE_W:1];
            sh_next  = {sum[0], sh_reg[PER_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        mc_reg  <= mc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {acc_reg, sh_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_sweep_with_shutter_core.sv =====
// triangle_sweep_with_shutter_core: triangle angle sweep and shutter pulse per event
// depends on tsws_pkg, tsws_if, tsws_div, tsws_mul
//
//   channel  dir  fields                       one beat is
//   in_ch    in   elapsed_us[39:0]             one encoder event
//   out_ch   out  angle_cmd[15:0] (Q2.13),     the result of one event
//                 shutter_pulse
//   cfg      in   cfg_we, cfg_index, cfg_data  one register write
//
// each event takes these steps in order: a pass of the bit-serial divider for
// t mod p, the shift-add multiplier, a second divider pass for the angle
// quotient, loading the output register, and a return to idle
// one event in flight at a time; in_ch.ready is high only in idle
// the output register holds a finished beat while the next event is worked on;
// a stalled out_ch only delays the hand-off at the end of the next event
// reset is immediate: no clearing pass, threshold cleared to zero
`default_nettype none

module triangle_sweep_with_shutter_core (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [tsws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [tsws_pkg::CFG_DAT_W-1:0]  cfg_data,
    tsws_in_if.sink                        in_ch,
    tsws_out_if.source                     out_ch
);
    import tsws_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;   // wait for an event
    localparam logic [2:0] S_MOD  = 3'd1;   // r = t mod p
    localparam logic [2:0] S_MUL  = 3'd2;   // |span| * |2r - p|
    localparam logic [2:0] S_DIV  = 3'd3;   // product / p
    localparam logic [2:0] S_OUT  = 3'd4;   // hand result to output register

    logic [2:0]         state_reg, state_next;

    // configuration
    logic [PER_W-1:0]   period_reg;
    logic [ANGLE_W-1:0] min_reg;
    logic [ANGLE_W-1:0] max_reg;

    // shutter state
    logic [THR_W-1:0]   thr_reg, thr_next;

    // per-event working registers
    logic [PER_W-1:0]   p_reg, p_next;
    logic [ANGLE_W-1:0] lo_reg, lo_next;
    logic [ANGLE_W-1:0] mag_reg, mag_next;     // |max - min|
    logic               neg_reg, neg_next;     // span below zero
    logic               pulse_reg, pulse_next;
    logic [ANGLE_W:0]   q_reg, q_next;         // |quotient| after rounding

    // output register
    logic               ovalid_reg, ovalid_next;
    logic [ANGLE_W-1:0] oangle_reg, oangle_next;
    logic               opulse_reg, opulse_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    logic               in_acc;
    logic [ANGLE_W:0]   span;
    logic [PER_W:0]     two_r;
    logic [PER_W:0]     p_ext;
    logic [PER_W-1:0]   fold_dist;
    logic [THR_W:0]     thr_sum;
    logic [ANGLE_W+1:0] q_signed;
    logic [ANGLE_W+1:0] angle_full;

    assign in_acc = in_ch.valid && in_ch.ready;

    // signed span, 17 bits wide so every register pattern fits
    assign span = {max_reg[ANGLE_W-1], max_reg} - {min_reg[ANGLE_W-1], min_reg};

    // distance from mid-period fold: |2r - p|, never above p
    assign two_r     = {div_rsp.remainder, 1'b0};
    assign p_ext     = {1'b0, p_reg};
    assign fold_dist = (two_r >= p_ext) ? PER_W'(two_r - p_ext) : PER_W'(p_ext - two_r);

    // threshold advance, carry out means saturate
    assign thr_sum = {1'b0, thr_reg} + {{(THR_W-PER_W+1){1'b0}}, p_reg};

    // angle = lo + signed quotient (floor on negative span)
    assign q_signed   = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign angle_full = {{2{lo_reg[ANGLE_W-1]}}, lo_reg} + q_signed;

    // shared divider: first pass folds time, second pass scales the angle
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = {{(DIVD_W-ELAPSED_W){1'b0}}, in_ch.elapsed_us};
        div_req.divisor  = p_next;
        if (state_reg == S_IDLE && in_acc)
            div_req.start = 1'b1;
        if (state_reg == S_MUL)
        begin
            div_req.dividend = mul_rsp.product;
            div_req.divisor  = p_reg;
            div_req.start    = mul_rsp.done;
        end
    end

    assign mul_req.start  = (state_reg == S_MOD) && div_rsp.done;
    assign mul_req.mcand  = mag_reg;
    assign mul_req.mplier = fold_dist;

    tsws_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tsws_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        thr_next    = thr_reg;
        p_next      = p_reg;
        lo_next     = lo_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        pulse_next  = pulse_reg;
        q_next      = q_reg;
        ovalid_next = ovalid_reg;
        oangle_next = oangle_reg;
        opulse_next = opulse_reg;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    // zero period acts as one
                    p_next     = (period_reg == '0) ? PER_W'(1) : period_reg;
                    lo_next    = min_reg;
                    neg_next   = span[ANGLE_W];
                    mag_next   = span[ANGLE_W] ? ANGLE_W'(-span) : span[ANGLE_W-1:0];
                    pulse_next = {in_ch.elapsed_us, 1'b0} > thr_reg;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    if (pulse_reg)
                        thr_next = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_rsp.done)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    // negative product rounds away from zero in magnitude
                    q_next = div_rsp.quotient[ANGLE_W:0]
                           + {{ANGLE_W{1'b0}}, neg_reg && (div_rsp.remainder != '0)};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    oangle_next = angle_full[ANGLE_W-1:0];
                    opulse_next = pulse_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            thr_reg    <= '0;
            period_reg <= PERIOD_RST;
            min_reg    <= MIN_ANGLE_RST;
            max_reg    <= MAX_ANGLE_RST;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            thr_reg    <= thr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PERIOD:    period_reg <= cfg_data;
                    CFG_MIN_ANGLE: min_reg    <= cfg_data[ANGLE_W-1:0];
                    CFG_MAX_ANGLE: max_reg    <= cfg_data[ANGLE_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        lo_reg     <= lo_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        pulse_reg  <= pulse_next;
        q_reg      <= q_next;
        oangle_reg <= oangle_next;
        opulse_reg <= opulse_next;
    end

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = ovalid_reg;
    assign out_ch.angle_cmd     = oangle_reg;
    assign out_ch.shutter_pulse = opulse_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tsws_check.sv =====
// tsws_check: port-level checks, bound into the sweep core
// depends on tsws_pkg and triangle_sweep_with_shutter_core
`default_nettype none

module tsws_check (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_valid,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [tsws_pkg::ANGLE_W-1:0] angle_cmd,
    input wire                         shutter_pulse
);
    import tsws_pkg::*;

    logic [1:0] pend_reg, pend_next;   // events taken but not yet delivered
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle_cmd) && $stable(shutter_pulse))
        else $error("result beat changed while stalled");

    // one event at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input accepted while busy");

    // no result beat without an event behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result beat without an event");

    // at most one event in work plus one waiting in the output register
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many events outstanding");

endmodule

bind triangle_sweep_with_shutter_core tsws_check u_tsws_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .angle_cmd     (out_ch.angle_cmd),
    .shutter_pulse (out_ch.shutter_pulse)
);

`default_nettype wire

// ===== verif/tb_triangle_sweep_with_shutter_core.sv =====
`timescale 1ns / 1ps
// tb_triangle_sweep_with_shutter_core: self-checking bench for the triangle sweep core,
// directed and random encoder events under random stalls, checked against an in-bench model
// depends on tsws_pkg, tsws_if and triangle_sweep_with_shutter_core

module tb_triangle_sweep_with_shutter_core;
    import tsws_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RAND_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 158;
    localparam int HOLD_CYCLES     = 600;    // long receiver hold-off in the pressure phase
    localparam int WATCHDOG_LIMIT  = 4000;   // cycles with no beat on either channel
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 160;    // final wait before the verdict
    localparam int ANGLE_LIM       = 25736;
    localparam int IDLE_PCT        = 22;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index, must be ignored
    localparam longint unsigned ELAPSED_MAX = (64'd1 << ELAPSED_W) - 1;

    // one result beat as the core should deliver it
    typedef struct packed {
        logic [ANGLE_W-1:0] angle_cmd;
        logic               shutter_pulse;
    } sweep_beat_t;

    // mirror of the register file and shutter threshold, plus the beats still due
    class sweep_checker;
        logic [PER_W-1:0]          period;
        logic signed [ANGLE_W-1:0] lo_angle;
        logic signed [ANGLE_W-1:0] hi_angle;
        logic [THR_W-1:0]          threshold;
        sweep_beat_t               due_beats[$];
        int                        errors;

        function new();
            period    = PERIOD_RST;
            lo_angle  = MIN_ANGLE_RST;
            hi_angle  = MAX_ANGLE_RST;
            threshold = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_PERIOD:    period   = data;
                CFG_MIN_ANGLE: lo_angle = data[ANGLE_W-1:0];
                CFG_MAX_ANGLE: hi_angle = data[ANGLE_W-1:0];
                default:       ;
            endcase
        endfunction

        // fold the time into the period, scale the triangle, floor the quotient
        function void note_event(logic [ELAPSED_W-1:0] t);
            longint unsigned p;
            longint unsigned r;
            longint unsigned twice_r;
            longint          fold;
            longint          base;
            longint          span;
            longint          num;
            longint          pp;
            longint          q;
            sweep_beat_t     beat;
            p       = (period == 0) ? 64'd1 : longint'(period);
            r       = longint'(t) % p;
            twice_r = r * 2;
            fold    = (twice_r >= p) ? longint'(twice_r - p) : longint'(p - twice_r);
            base    = lo_angle;
            span    = longint'(hi_angle) - base;
            num     = span * fold;
            pp      = p;
            if (num >= 0)
                q = num / pp;
            else
                q = -((-num + pp - 1) / pp);
            beat.angle_cmd     = ANGLE_W'(base + q);
            beat.shutter_pulse = 1'b0;
            if ({t, 1'b0} > threshold)
            begin
                beat.shutter_pulse = 1'b1;
                // saturate rather than wrap
                if (longint'(threshold) > longint'(THR_MAX) - p)
                    threshold = THR_MAX;
                else
                    threshold = threshold + THR_W'(p);
            end
            due_beats.push_back(beat);
        endfunction

        function void check_beat(logic [ANGLE_W-1:0] angle, logic pulse);
            sweep_beat_t want;
            if (due_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat: angle_cmd %0d shutter_pulse %0b",
                         $time, $signed(angle), pulse);
                return;
            end
            want = due_beats.pop_front();
            if (angle !== want.angle_cmd)
            begin
                errors++;
                $display("%0t: angle_cmd expected %0d got %0d", $time,
                         $signed(want.angle_cmd), $signed(angle));
            end
            if (pulse !== want.shutter_pulse)
            begin
                errors++;
                $display("%0t: shutter_pulse expected %0b got %0b", $time,
                         want.shutter_pulse, pulse);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    tsws_in_if  in_ch();
    tsws_out_if out_ch();

    sweep_checker ledger = new();

    bit idle_on;        // random idling on both channels
    bit hold_out;       // one-shot request for a long receiver hold-off
    int quiet_cycles;

    triangle_sweep_with_shutter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // receiver: ready moves on the falling edge, random idling or one long hold-off
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                hold_out = 1'b0;
                out_ch.ready <= 1'b0;
                // count the hold-off here so the sender keeps offering beats meanwhile
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // every accepted result beat is checked against the oldest due beat
    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            ledger.check_beat(out_ch.angle_cmd, out_ch.shutter_pulse);

    // watchdog: no beat on either channel for too long ends the run
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("triangle_sweep_with_shutter_core: mismatch");
            $finish;
        end
    end

    // one register write per cycle; caller lowers cfg_we afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        ledger.write_reg(idx, data);
        @(negedge clk);
    endtask

    // full register set while the core is idle; angle writes carry junk in the upper bits
    task automatic apply_settings(input logic [PER_W-1:0] per,
                                  input logic signed [ANGLE_W-1:0] lo,
                                  input logic signed [ANGLE_W-1:0] hi,
                                  input bit spare);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_MIN_ANGLE, {(CFG_DAT_W - ANGLE_W)'($urandom), lo});
        write_reg(CFG_MAX_ANGLE, {(CFG_DAT_W - ANGLE_W)'($urandom), hi});
        if (spare)
            write_reg(CFG_SPARE, CFG_DAT_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // offer one event beat, with random idle cycles ahead of it
    task automatic send_event(input logic [ELAPSED_W-1:0] t);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.elapsed_us <= t;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        ledger.note_event(t);
        @(negedge clk);
    endtask

    // stop offering, wait for every due beat, then let the core settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (ledger.due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 4))
            0:       return ANGLE_W'(-ANGLE_LIM);
            1:       return ANGLE_W'(ANGLE_LIM);
            default: return ANGLE_W'(int'($urandom_range(0, 2 * ANGLE_LIM)) - ANGLE_LIM);
        endcase
    endfunction

    task automatic random_settings();
        logic [PER_W-1:0] per;
        case ($urandom_range(0, 6))
            0:       per = '0;
            1:       per = PER_W'($urandom_range(1, 16));
            2:       per = PER_W'($urandom_range(17, 1000));
            3:       per = PER_W'($urandom_range(1001, 1 << 20));
            4:       per = PER_W'($urandom);
            5:       per = {PER_W{1'b1}} - PER_W'($urandom_range(0, 255));
            default: per = PER_W'($urandom_range(2, 64));
        endcase
        apply_settings(per, pick_angle(), pick_angle(), $urandom_range(0, 1));
    endtask

    // mostly rising time sequences that walk across the shutter threshold,
    // some repeated or backward times, some full-range noise
    task automatic run_phase(input int n);
        longint unsigned cur;
        longint unsigned p;
        longint unsigned step;
        logic [ELAPSED_W-1:0] t;
        int kind;
        p   = (ledger.period == 0) ? 64'd1 : longint'(ledger.period);
        cur = ledger.threshold >> 1;
        repeat (n)
        begin
            kind = $urandom_range(99);
            step = $urandom_range(0, p);
            if (kind < 75)
            begin
                cur = cur + step;
                if (cur > ELAPSED_MAX)
                    cur = ledger.threshold >> 1;
                t = ELAPSED_W'(cur);
            end
            else if (kind < 85)
                t = (step > cur) ? '0 : ELAPSED_W'(cur - step);
            else
                t = {8'($urandom), 32'($urandom)};
            send_event(t);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.elapsed_us = '0;
        idle_on          = 1'b1;
        hold_out         = 1'b0;
        quiet_cycles     = 0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings written back explicitly: start of sweep, quarter and
        // half period, period wrap, the threshold edge and the largest time
        apply_settings(PERIOD_RST, MIN_ANGLE_RST, MAX_ANGLE_RST, 1'b0);
        send_event(40'd0);
        send_event(40'd1);
        send_event(40'd2500000);
        send_event(40'd2500001);
        send_event(40'd4999999);
        send_event(40'd5000000);
        send_event(40'd1250000);
        send_event({ELAPSED_W{1'b1}});
        send_event(40'd3);
        drain();

        // zero period acts as one, full angle range, unmapped index written
        apply_settings('0, ANGLE_W'(-ANGLE_LIM), ANGLE_W'(ANGLE_LIM), 1'b1);
        send_event(40'd0);
        send_event(40'd12345);
        send_event(40'hAA_AAAA_AAAA);
        send_event(40'h55_5555_5555);
        drain();

        // largest period with reversed limits, points next to mid-period
        apply_settings({PER_W{1'b1}}, ANGLE_W'(ANGLE_LIM), ANGLE_W'(-ANGLE_LIM), 1'b0);
        send_event(40'd0);
        send_event(40'd33554431);
        send_event(40'd33554432);
        send_event(40'd67108862);
        send_event(40'd67108863);
        send_event(40'd16777216);
        drain();

        // tiny odd period with equal limits
        apply_settings(PER_W'(3), ANGLE_W'(-1), ANGLE_W'(-1), 1'b1);
        send_event(40'd0);
        send_event(40'd1);
        send_event(40'd2);
        drain();

        // random settings per phase; one phase runs without idling and one
        // opens with a long receiver hold-off so the core backs up
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            random_settings();
            idle_on = (ph != 2);
            if (ph == 5)
                hold_out = 1'b1;
            run_phase(ITEMS_PER_PHASE);
            drain();
        end
        idle_on = 1'b1;

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (ledger.errors == 0 && ledger.due_beats.size() == 0)
            $display("triangle_sweep_with_shutter_core: match");
        else
            $display("triangle_sweep_with_shutter_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tsws_pkg.sv
hw/rtl/tsws_if.sv
hw/rtl/tsws_div.sv
hw/rtl/tsws_mul.sv
hw/rtl/triangle_sweep_with_shutter_core.sv
hw/rtl/tsws_check.sv
verif/tb_triangle_sweep_with_shutter_core.sv
